FILE: rtl/core/pva_pkg.sv
// ---------------------------------------------------------------------------
// pva_pkg
// Shared types, operation codes, the CORDIC arctangent table and a saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none
package pva_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_SUB  = 3'd1,
    FUNC_MUL  = 3'd2,
    FUNC_DIV  = 3'd3,
    FUNC_CART = 3'd4
  } func_t;

  localparam int XW = 36;  // CORDIC datapath width

  typedef logic signed [XW-1:0] cx_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [95:0] v);
    logic [31:0] r;
    if (v > 96'sd2147483647) r = 32'h7fffffff;
    else if (v < -96'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pva_cell.sv
// ---------------------------------------------------------------------------
// pva_cell
// One pipeline cell: two rotation CORDIC micro-steps and one vectoring
// micro-step (if IDX < NSTG), one restoring divide step; carries the payload.
// ---------------------------------------------------------------------------
`default_nettype none
module pva_cell #(
  parameter int IDX = 0,
  parameter int NSTG = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               v_i,
  input  wire logic [2:0]         f_i,
  input  wire pva_pkg::cx_t       ax_i, ay_i, bx_i, by_i,
  input  wire logic signed [32:0] az_i, bz_i,
  input  wire pva_pkg::cx_t       vx_i, vy_i,
  input  wire logic [31:0]        vz_i,
  input  wire logic [63:0]        q_i, r_i,
  input  wire logic [63:0]        d_i,
  input  wire logic [33:0]        keep_i,
  output logic                    v_o,
  output logic [2:0]              f_o,
  output pva_pkg::cx_t            ax_o, ay_o, bx_o, by_o,
  output logic signed [32:0]      az_o, bz_o,
  output pva_pkg::cx_t            vx_o, vy_o,
  output logic [31:0]             vz_o,
  output logic [63:0]             q_o, r_o,
  output logic [63:0]             d_o,
  output logic [33:0]             keep_o
);
  localparam logic [4:0] SI = 5'(IDX);
  localparam int SH = IDX;

  pva_pkg::cx_t ax_nxt, ay_nxt, bx_nxt, by_nxt, vx_nxt, vy_nxt;
  logic signed [32:0] az_nxt, bz_nxt, at;
  logic [31:0] vz_nxt;
  logic [64:0] rs;
  logic [63:0] q_nxt, r_nxt;

  always_comb begin
    at = $signed({1'b0, pva_pkg::atan_turn(SI)});
    if (IDX < NSTG) begin
      if (!az_i[32]) begin
        ax_nxt = ax_i - (ay_i >>> SH); ay_nxt = ay_i + (ax_i >>> SH); az_nxt = az_i - at;
      end else begin
        ax_nxt = ax_i + (ay_i >>> SH); ay_nxt = ay_i - (ax_i >>> SH); az_nxt = az_i + at;
      end
      if (!bz_i[32]) begin
        bx_nxt = bx_i - (by_i >>> SH); by_nxt = by_i + (bx_i >>> SH); bz_nxt = bz_i - at;
      end else begin
        bx_nxt = bx_i + (by_i >>> SH); by_nxt = by_i - (bx_i >>> SH); bz_nxt = bz_i + at;
      end
      if (vy_i < 0) begin
        vx_nxt = vx_i - (vy_i >>> SH); vy_nxt = vy_i + (vx_i >>> SH);
        vz_nxt = vz_i - at[31:0];
      end else begin
        vx_nxt = vx_i + (vy_i >>> SH); vy_nxt = vy_i - (vx_i >>> SH);
        vz_nxt = vz_i + at[31:0];
      end
    end else begin
      ax_nxt = ax_i; ay_nxt = ay_i; az_nxt = az_i;
      bx_nxt = bx_i; by_nxt = by_i; bz_nxt = bz_i;
      vx_nxt = vx_i; vy_nxt = vy_i; vz_nxt = vz_i;
    end
    rs = {r_i, q_i[63]} - {1'b0, d_i};
    if (!rs[64]) begin
      r_nxt = rs[63:0]; q_nxt = {q_i[62:0], 1'b1};
    end else begin
      r_nxt = {r_i[62:0], q_i[63]}; q_nxt = {q_i[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
    if (en) begin
      f_o <= f_i; ax_o <= ax_nxt; ay_o <= ay_nxt; az_o <= az_nxt;
      bx_o <= bx_nxt; by_o <= by_nxt; bz_o <= bz_nxt;
      vx_o <= vx_nxt; vy_o <= vy_nxt; vz_o <= vz_nxt;
      q_o <= q_nxt; r_o <= r_nxt; d_o <= d_i; keep_o <= keep_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/polar_vector_alu_unit.sv
// ---------------------------------------------------------------------------
// polar_vector_alu_unit
// Polar vector add, subtract, scale, divide and to-cartesian.
// ---------------------------------------------------------------------------
// Usage: present an item on in_* with in_valid; it is taken when in_ready
// is high. Results leave on out_* with out_valid/out_ready, in order.
// The datapath is two chains of 64 pva_cell instances plus the fixed
// capture, prescale, mid, final and output stages. The first chain does
// rotation CORDIC (both vectors side by side) and the restoring divide,
// one quotient bit per cell; the second chain does vectoring CORDIC.
// Throughput: one item per cycle unless stalled; the whole chain advances
// together. When out_ready is low while a result waits, the chain holds and
// in_ready drops until the output register is freed. Reset clears all
// valid flags; no item is in flight afterwards.
// ---------------------------------------------------------------------------
`default_nettype none
module polar_vector_alu_unit #(
  parameter int LEN_FRAC_BITS = 16,
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_func,
  input  wire logic signed [31:0]    in_len_a,
  input  wire logic [ANGLE_BITS-1:0] in_ang_a,
  input  wire logic signed [31:0]    in_len_b,
  input  wire logic [ANGLE_BITS-1:0] in_ang_b,
  input  wire logic signed [31:0]    in_scale,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_res_length,
  output logic [ANGLE_BITS-1:0]      out_res_angle,
  output logic signed [31:0]         out_res_x,
  output logic signed [31:0]         out_res_y,
  output logic                       out_div_zero
);
  localparam int N = 64;
  localparam int AS = 32 - ANGLE_BITS;

  function automatic logic [63:0] cdiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0; r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d; q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] gain_k();
    logic [63:0] p, n, r, b;
    p = 64'd1 << 32;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
      p = p - cdiv64(p, (64'd1 << (2 * i)) + 64'd1);
    n = p << 32; r = 64'd0; b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin n = n - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction
  localparam logic [63:0] K = gain_k();

  logic en;
  // stage 0: operand capture
  logic s0v_r; logic [2:0] s0f_r;
  logic signed [31:0] s0la_r, s0lb_r, s0sc_r; logic [31:0] s0aa_r, s0ab_r;
  // stage 1: gain prescale and scale product
  logic s1v_r; logic [2:0] s1f_r;
  logic signed [95:0] s1pa_r, s1pb_r, s1m_r;
  logic [31:0] s1aa_r, s1ab_r; logic signed [31:0] s1la_r, s1sc_r;

  logic v_c [N+1]; logic [2:0] f_c [N+1];
  pva_pkg::cx_t ax_c [N+1], ay_c [N+1], bx_c [N+1], by_c [N+1];
  pva_pkg::cx_t vx_c [N+1], vy_c [N+1];
  logic signed [32:0] az_c [N+1], bz_c [N+1];
  logic [31:0] vz_c [N+1]; logic [63:0] q_c [N+1], r_c [N+1], d_c [N+1];
  logic [33:0] keep_c [N+1];
  logic v2 [N+1]; logic [2:0] f2 [N+1];
  pva_pkg::cx_t ax2 [N+1], ay2 [N+1], bx2 [N+1], by2 [N+1], vx2 [N+1], vy2 [N+1];
  logic signed [32:0] az2 [N+1], bz2 [N+1];
  logic [31:0] vz2 [N+1]; logic [63:0] q2 [N+1], r2 [N+1], d2 [N+1];
  logic [33:0] keep2 [N+1];

  // mid stage: combine and fold for vectoring
  logic mv_r; logic [2:0] mf_r; logic mneg_r;
  pva_pkg::cx_t mx_r, my_r; logic [33:0] mk_r;
  logic [63:0] mq_r;
  // final stages
  logic e1v_r; logic [2:0] e1f_r; logic [31:0] e1z32_r; logic [33:0] e1k_r;
  logic [63:0] e1hi_r, e1lo_r, e1q_r; logic signed [95:0] e1m_r, e1d_r;

  logic ov_r; logic [2:0] ovf;
  logic [31:0] ol_r, oa_r, ox_r, oy_r; logic odz_r;

  assign en = !ov_r || out_ready;
  assign in_ready = en;

  function automatic pva_pkg::cx_t rot_x(input logic signed [95:0] p, input logic flip);
    pva_pkg::cx_t x;
    x = p[32+pva_pkg::XW-1:32];
    return flip ? -x : x;
  endfunction

  logic fa, fb;
  logic [31:0] za, zb;
  logic neg_s, neg_l; logic [63:0] ula, usc;
  always_comb begin
    fa = s1aa_r[31] ^ s1aa_r[30];
    fb = s1ab_r[31] ^ s1ab_r[30];
    za = fa ? s1aa_r - 32'h80000000 : s1aa_r;
    zb = fb ? s1ab_r - 32'h80000000 : s1ab_r;
    neg_l = s1la_r[31]; neg_s = s1sc_r[31];
    ula = {32'd0, neg_l ? -s1la_r : s1la_r} << LEN_FRAC_BITS;
    usc = {32'd0, neg_s ? -s1sc_r : s1sc_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0v_r <= 1'b0; s1v_r <= 1'b0;
    end else if (en) begin
      s0v_r <= in_valid; s1v_r <= s0v_r;
    end
    if (en) begin
      s0f_r <= in_func; s0la_r <= in_len_a; s0lb_r <= in_len_b; s0sc_r <= in_scale;
      s0aa_r <= 32'(in_ang_a) << AS; s0ab_r <= 32'(in_ang_b) << AS;
      s1f_r <= s0f_r; s1aa_r <= s0aa_r; s1ab_r <= s0ab_r;
      s1la_r <= s0la_r; s1sc_r <= s0sc_r;
      s1pa_r <= 96'(s0la_r) * $signed({32'd0, K});
      s1pb_r <= 96'(s0lb_r) * $signed({32'd0, K});
      s1m_r <= 96'(s0la_r) * 96'(s0sc_r);
    end
  end

  assign v_c[0] = s1v_r; assign f_c[0] = s1f_r;
  assign ax_c[0] = rot_x(s1pa_r, fa); assign ay_c[0] = '0;
  assign bx_c[0] = rot_x(s1pb_r, fb); assign by_c[0] = '0;
  assign az_c[0] = $signed({za[31], za}); assign bz_c[0] = $signed({zb[31], zb});
  assign vx_c[0] = '0; assign vy_c[0] = '0; assign vz_c[0] = '0;
  assign q_c[0] = ula; assign r_c[0] = '0; assign d_c[0] = usc;
  assign keep_c[0] = {s1aa_r, neg_l ^ neg_s, s1sc_r == 0};

  for (genvar g = 0; g < N; g++) begin : g_rot
    pva_cell #(.IDX(g < 32 ? g : 31), .NSTG(g < 32 ? CORDIC_STAGES : 0)) u_cell (
      .clk, .rst_n, .en,
      .v_i(v_c[g]), .f_i(f_c[g]), .ax_i(ax_c[g]), .ay_i(ay_c[g]), .bx_i(bx_c[g]),
      .by_i(by_c[g]), .az_i(az_c[g]), .bz_i(bz_c[g]), .vx_i(vx_c[g]), .vy_i(vy_c[g]),
      .vz_i(vz_c[g]), .q_i(q_c[g]), .r_i(r_c[g]), .d_i(d_c[g]), .keep_i(keep_c[g]),
      .v_o(v_c[g+1]), .f_o(f_c[g+1]), .ax_o(ax_c[g+1]), .ay_o(ay_c[g+1]),
      .bx_o(bx_c[g+1]), .by_o(by_c[g+1]), .az_o(az_c[g+1]), .bz_o(bz_c[g+1]),
      .vx_o(vx_c[g+1]), .vy_o(vy_c[g+1]), .vz_o(vz_c[g+1]), .q_o(q_c[g+1]),
      .r_o(r_c[g+1]), .d_o(d_c[g+1]), .keep_o(keep_c[g+1]));
  end

  pva_pkg::cx_t sx, sy;
  always_comb begin
    if (f_c[N] == pva_pkg::FUNC_ADD) begin
      sx = ax_c[N] + bx_c[N]; sy = ay_c[N] + by_c[N];
    end else begin
      sx = ax_c[N] - bx_c[N]; sy = ay_c[N] - by_c[N];
    end
  end

  // q carries the quotient, the saturated cartesian pair or the zero-vector flag
  logic [63:0] mq_nxt;
  always_comb begin
    unique case (f_c[N])
      pva_pkg::FUNC_DIV: mq_nxt = q_c[N];
      pva_pkg::FUNC_CART:
        mq_nxt = {pva_pkg::sat32(96'(ax_c[N])), pva_pkg::sat32(96'(ay_c[N]))};
      default: mq_nxt = {63'd0, (sx == 0) && (sy == 0)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= v_c[N];
    end
    if (en) begin
      mf_r <= f_c[N]; mneg_r <= sx < 0;
      mx_r <= sx < 0 ? -sx : sx; my_r <= sx < 0 ? -sy : sy;
      mk_r <= keep_c[N]; mq_r <= mq_nxt;
    end
  end

  assign v2[0] = mv_r; assign f2[0] = mf_r;
  assign ax2[0] = '0; assign ay2[0] = '0; assign bx2[0] = '0; assign by2[0] = '0;
  assign az2[0] = '0; assign bz2[0] = '0;
  assign vx2[0] = mx_r; assign vy2[0] = my_r; assign vz2[0] = mneg_r ? 32'h80000000 : '0;
  assign q2[0] = mq_r; assign r2[0] = '0; assign d2[0] = 64'd1; assign keep2[0] = mk_r;

  for (genvar g = 0; g < N; g++) begin : g_vec
    pva_cell #(.IDX(g < 32 ? g : 31), .NSTG(g < 32 ? CORDIC_STAGES : 0)) u_cell (
      .clk, .rst_n, .en,
      .v_i(v2[g]), .f_i(f2[g]), .ax_i(ax2[g]), .ay_i(ay2[g]), .bx_i(bx2[g]),
      .by_i(by2[g]), .az_i(az2[g]), .bz_i(bz2[g]), .vx_i(vx2[g]), .vy_i(vy2[g]),
      .vz_i(vz2[g]), .q_i(q2[g]), .r_i(r2[g]), .d_i(d2[g]), .keep_i(keep2[g]),
      .v_o(v2[g+1]), .f_o(f2[g+1]), .ax_o(ax2[g+1]), .ay_o(ay2[g+1]),
      .bx_o(bx2[g+1]), .by_o(by2[g+1]), .az_o(az2[g+1]), .bz_o(bz2[g+1]),
      .vx_o(vx2[g+1]), .vy_o(vy2[g+1]), .vz_o(vz2[g+1]), .q_o(q2[g+1]),
      .r_o(r2[g+1]), .d_o(d2[g+1]), .keep_o(keep2[g+1]));
  end

  // The second chain divides by one, so q passes through unchanged.
  logic [63:0] uvx;
  assign uvx = 64'(vx2[N]);
  assign ovf = f2[N];

  // multiply product travels alongside as a held register chain
  logic signed [95:0] mchain [2*N+2];
  assign mchain[0] = s1m_r;
  for (genvar g = 0; g < 2*N+1; g++) begin : g_mul
    always_ff @(posedge clk) if (en) mchain[g+1] <= mchain[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1v_r <= 1'b0;
    end else if (en) begin
      e1v_r <= v2[N];
    end
    if (en) begin
      e1f_r <= ovf; e1q_r <= q2[N]; e1z32_r <= vz2[N]; e1k_r <= keep2[N];
      e1hi_r <= {32'd0, uvx[63:32]} * K;
      e1lo_r <= ({32'd0, uvx[31:0]} * K) >> 32;
      e1m_r <= mchain[2*N+1] >>> LEN_FRAC_BITS;
      e1d_r <= keep2[N][1] ? -$signed({32'd0, q2[N]}) : $signed({32'd0, q2[N]});
    end
  end

  logic [31:0] ln, an, xn, yn; logic dzn;
  always_comb begin
    ln = '0; an = '0; xn = '0; yn = '0; dzn = 1'b0;
    unique case (e1f_r)
      pva_pkg::FUNC_ADD, pva_pkg::FUNC_SUB: begin
        if (!e1q_r[0]) begin
          ln = pva_pkg::sat32($signed({32'd0, e1hi_r + e1lo_r}));
          an = e1z32_r >> AS;
        end
      end
      pva_pkg::FUNC_MUL: begin
        ln = pva_pkg::sat32(e1m_r); an = e1k_r[33:2] >> AS;
      end
      pva_pkg::FUNC_DIV: begin
        if (e1k_r[0]) dzn = 1'b1;
        else begin
          ln = pva_pkg::sat32(e1d_r); an = e1k_r[33:2] >> AS;
        end
      end
      pva_pkg::FUNC_CART: begin
        xn = e1q_r[63:32]; yn = e1q_r[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= e1v_r;
    end
    if (en) begin
      ol_r <= ln; oa_r <= an; ox_r <= xn; oy_r <= yn; odz_r <= dzn;
    end
  end

  assign out_valid = ov_r;
  assign out_res_length = ol_r;
  assign out_res_angle = oa_r[ANGLE_BITS-1:0];
  assign out_res_x = ox_r;
  assign out_res_y = oy_r;
  assign out_div_zero = odz_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_length))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_length == 0) else $error("div zero length");
endmodule
`default_nettype wire

FILE: tb/sv/tb_polar_vector_alu_unit.sv
// ---------------------------------------------------------------------------
// tb_polar_vector_alu_unit
// Self-checking bench for the polar vector unit: directed corner items and
// random items run through a bit-exact CORDIC/scale/divide predictor, with
// random sender gaps and receiver stalls, a long output hold-off and a drain.
// ---------------------------------------------------------------------------
typedef struct packed {
  logic [31:0] len;
  logic [31:0] ang;
  logic [31:0] x;
  logic [31:0] y;
  logic        dz;
} pva_result_t;

class pva_result_book;
  pva_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned checked;
  longint unsigned k_gain;
  logic [31:0] atan_lut[24];

  function new();
    longint unsigned p, n, r, b;
    atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    mismatches = 0;
    checked = 0;
    p = 64'd1 << 32;
    for (int i = 0; i < 24; i++) p = p - p / ((64'd1 << (2 * i)) + 1);
    n = p << 32;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    k_gain = r;
  endfunction

  function logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function void rotate_vec(longint len, logic [31:0] ang, output longint xo, output longint yo);
    longint x, y, z, dx, dy;
    logic [31:0] q;
    x = (len * longint'(k_gain)) >>> 32;
    y = 0;
    q = ang + 32'h40000000;
    if (q[31]) begin
      x = -x;
      ang = ang - 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_lut[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_lut[i]);
      end
    end
    xo = x;
    yo = y;
  endfunction

  function void to_polar(longint x, longint y, output longint len, output logic [31:0] ang);
    logic [31:0] z;
    longint dx, dy;
    longint unsigned ux, lv;
    z = 0;
    if (x == 0 && y == 0) begin
      len = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx; y = y + dy; z = z - atan_lut[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_lut[i];
      end
    end
    ux = x;
    lv = (ux >> 32) * k_gain + (((ux & 64'hffffffff) * k_gain) >> 32);
    len = longint'(lv);
    ang = z;
  endfunction

  function void note_item(logic [2:0] f, logic signed [31:0] la, logic [31:0] aa,
                          logic signed [31:0] lb, logic [31:0] ab,
                          logic signed [31:0] sc);
    pva_result_t e;
    longint x1, y1, x2, y2, l;
    logic [31:0] a;
    e = '{default: '0};
    if (f == pva_pkg::FUNC_ADD || f == pva_pkg::FUNC_SUB) begin
      rotate_vec(longint'(la), aa, x1, y1);
      rotate_vec(longint'(lb), ab, x2, y2);
      if (f == pva_pkg::FUNC_ADD) begin
        x1 = x1 + x2; y1 = y1 + y2;
      end else begin
        x1 = x1 - x2; y1 = y1 - y2;
      end
      to_polar(x1, y1, l, a);
      e.len = clamp32(l);
      e.ang = a;
    end else if (f == pva_pkg::FUNC_MUL) begin
      e.len = clamp32((longint'(la) * longint'(sc)) >>> 16);
      e.ang = aa;
    end else if (f == pva_pkg::FUNC_DIV) begin
      if (sc == 0) begin
        e.dz = 1'b1;
      end else begin
        e.len = clamp32((longint'(la) * 64'sd65536) / longint'(sc));
        e.ang = aa;
      end
    end else if (f == pva_pkg::FUNC_CART) begin
      rotate_vec(longint'(la), aa, x1, y1);
      e.x = clamp32(x1);
      e.y = clamp32(y1);
    end
    pending_results.push_back(e);
  endfunction

  function void check_result(pva_result_t act);
    pva_result_t e;
    checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with nothing pending: len=%h", act.len);
      return;
    end
    e = pending_results.pop_front();
    if (act !== e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d exp len=%h ang=%h x=%h y=%h dz=%b got len=%h ang=%h x=%h y=%h dz=%b",
                 checked, e.len, e.ang, e.x, e.y, e.dz,
                 act.len, act.ang, act.x, act.y, act.dz);
    end
  endfunction
endclass

module tb_polar_vector_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] FUNC_RSV_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSV_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic signed [31:0] in_len_a = '0;
  logic [31:0] in_ang_a = '0;
  logic signed [31:0] in_len_b = '0;
  logic [31:0] in_ang_b = '0;
  logic signed [31:0] in_scale = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_length;
  logic [31:0] out_res_angle;
  logic signed [31:0] out_res_x;
  logic signed [31:0] out_res_y;
  logic out_div_zero;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned op_count[8];
  pva_result_book book;

  polar_vector_alu_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_len_a(in_len_a), .in_ang_a(in_ang_a),
    .in_len_b(in_len_b), .in_ang_b(in_ang_b), .in_scale(in_scale),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_length(out_res_length), .out_res_angle(out_res_angle),
    .out_res_x(out_res_x), .out_res_y(out_res_y), .out_div_zero(out_div_zero)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result('{out_res_length, out_res_angle, out_res_x, out_res_y, out_div_zero});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[polar_vector_alu_unit] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(logic [2:0] f, logic [31:0] la, logic [31:0] aa,
                           logic [31:0] lb, logic [31:0] ab, logic [31:0] sc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_len_a <= la;
    in_ang_a <= aa;
    in_len_b <= lb;
    in_ang_b <= ab;
    in_scale <= sc;
    do @(posedge clk); while (!in_ready);
    book.note_item(f, la, aa, lb, ab, sc);
    op_count[f]++;
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h001fffff) - 32'h00100000;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom_range(200) - 100;
      4: return 32'h0;
      default: return $urandom_range(32'h0fffffff) - 32'h08000000;
    endcase
  endfunction

  function automatic logic [31:0] pick_ang();
    if ($urandom_range(3) == 0)
      return {2'($urandom_range(3)), 30'h0} + $urandom_range(2) - 32'd1;
    return $urandom;
  endfunction

  task automatic send_random();
    logic [2:0] f;
    logic [31:0] sc;
    f = ($urandom_range(99) < 4) ? 3'($urandom_range(FUNC_RSV_FIRST, FUNC_RSV_LAST))
                                 : 3'($urandom_range(pva_pkg::FUNC_CART));
    sc = ($urandom_range(9) == 0) ? 32'h0 : pick_len();
    send_item(f, pick_len(), pick_ang(), pick_len(), pick_ang(), sc);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    book = new();
    foreach (op_count[i]) op_count[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pva_pkg::FUNC_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_ADD, 32'h00010000, 32'h0, 32'h00010000, 32'h80000000, 32'h0);
    send_item(pva_pkg::FUNC_SUB, 32'h00020000, 32'h12345678, 32'h00020000, 32'h12345678,
              32'h0);
    send_item(pva_pkg::FUNC_ADD, 32'h7fffffff, 32'h40000000, 32'h7fffffff, 32'h40000000,
              32'h0);
    send_item(pva_pkg::FUNC_SUB, 32'h80000000, 32'hffffffff, 32'h7fffffff, 32'hc0000000,
              32'h0);
    send_item(pva_pkg::FUNC_MUL, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'h0, 32'h7fffffff);
    send_item(pva_pkg::FUNC_MUL, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
    send_item(pva_pkg::FUNC_MUL, 32'hffffffff, 32'h1, 32'h0, 32'h0, 32'h00000001);
    send_item(pva_pkg::FUNC_DIV, 32'h00050000, 32'h40000000, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_DIV, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'hffffffff);
    send_item(pva_pkg::FUNC_DIV, 32'h7fffffff, 32'h1, 32'h0, 32'h0, 32'h00000001);
    send_item(pva_pkg::FUNC_DIV, 32'hfffe0000, 32'h7fffffff, 32'h0, 32'h0, 32'h00030000);
    send_item(pva_pkg::FUNC_CART, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_CART, 32'h7fffffff, 32'h40000000, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_CART, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_CART, 32'h7fffffff, 32'hc0000000, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_CART, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0);
    send_item(pva_pkg::FUNC_CART, 32'h7fffffff, 32'h3fffffff, 32'h0, 32'h0, 32'h0);
    for (int f = FUNC_RSV_FIRST; f <= FUNC_RSV_LAST; f++)
      send_item(3'(f), 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    drain();

    hold_left = HOLD_CYCLES;
    repeat (250) send_random();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 83; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 83; end
        default: begin sender_idle_pct = 7; stall_pct = 7; end
      endcase
      repeat (240) send_random();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d add, %0d sub, %0d mul, %0d div, %0d cart, %0d reserved items",
             op_count[pva_pkg::FUNC_ADD], op_count[pva_pkg::FUNC_SUB],
             op_count[pva_pkg::FUNC_MUL], op_count[pva_pkg::FUNC_DIV],
             op_count[pva_pkg::FUNC_CART],
             op_count[FUNC_RSV_FIRST] + op_count[FUNC_RSV_FIRST + 3'd1] +
             op_count[FUNC_RSV_LAST]);
    $display("%0d results checked, %0d mismatches", book.checked, book.mismatches);
    if (book.mismatches == 0 && book.pending_results.size() == 0)
      $display("[polar_vector_alu_unit] OK");
    else
      $display("[polar_vector_alu_unit] ERROR");
    $finish;
  end
endmodule
